[sv/otsu_pkg.sv]
package otsu_pkg;

   localparam int LEVELS     = 256;
   localparam int LVL_W      = 8;
   localparam int BIN_W      = 18;
   localparam int BIN_MAX    = 262143;
   localparam int PIXELS_MAX = 131072;
   localparam int PCNT_W     = 18;
   localparam int MSUM_W     = 25;
   localparam int NUM_W      = MSUM_W + 8;
   localparam int MU_W       = 16;
   localparam int DD_W       = 2 * MU_W;
   localparam int DDS_W      = DD_W - 8;
   localparam int WW_W       = 2 * BIN_W;
   localparam int WH_W       = WW_W / 2;
   localparam int PP_W       = DDS_W + WH_W;
   localparam int SCORE_W    = PP_W + WH_W;
   localparam int TOKQ_DEPTH = 2;
   localparam int TOKQ_CNT_W = 2;

   typedef struct packed {
      logic [LVL_W-1:0] rd_addr;
      logic             clear;
   } back_req_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SUM_RD,
      BK_SUM_ACC,
      BK_EV_RD,
      BK_EV_ACC,
      BK_DIV_GO,
      BK_DIV_WAIT,
      BK_DIFF,
      BK_SQR,
      BK_PART,
      BK_SCORE,
      BK_CLEAR,
      BK_EMIT
   } back_state_type;

endpackage

[sv/otsu_ram.sv]
module otsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/otsu_front.sv]
module otsu_front import otsu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_pixel,
   input  logic              req_frame_end,
   input  back_req_type      bk_req,
   output logic [BIN_W-1:0]  bin_data,
   input  logic              q_full,
   output logic              q_push
);

   logic [LEVELS-1:0] valid_ff;
   logic              wait_ff;
   logic [PCNT_W-1:0] pix_cnt_ff;
   logic              s1_valid_ff;
   logic              s1_count_ff;
   logic              s1_last_ff;
   logic [LVL_W-1:0]  rd_addr_ff;
   logic [LVL_W-1:0]  rd_addr_in;
   logic              wr_valid_ff;
   logic [LVL_W-1:0]  wr_addr_ff;
   logic [BIN_W-1:0]  wr_data_ff;
   logic [BIN_W-1:0]  ram_q;
   logic [BIN_W-1:0]  base;
   logic [BIN_W-1:0]  incr;
   logic              accept;
   logic              count_en;
   logic              we;
   logic              fwd;

   assign req_ready  = !wait_ff && !q_full;
   assign accept     = req_valid && req_ready;
   assign count_en   = pix_cnt_ff < PCNT_W'(PIXELS_MAX);
   assign rd_addr_in = wait_ff ? bk_req.rd_addr : req_pixel;

   otsu_ram #(.WIDTH(BIN_W), .DEPTH(LEVELS)) u_bins (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (rd_addr_ff),
      .wr_data (incr),
      .rd_addr (rd_addr_in),
      .rd_data (ram_q)
   );

   // bins not yet written this frame read as zero
   assign bin_data = valid_ff[rd_addr_ff] ? ram_q : '0;

   // write of the previous cycle is not yet seen by the read-first port
   assign fwd  = wr_valid_ff && (wr_addr_ff == rd_addr_ff);
   assign base = fwd ? wr_data_ff : bin_data;
   assign incr = (base == BIN_W'(BIN_MAX)) ? base : base + BIN_W'(1);
   assign we   = s1_valid_ff && s1_count_ff;
   assign q_push = s1_valid_ff && s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         wait_ff     <= 1'b0;
         pix_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         wr_valid_ff <= we;
         if (we) begin
            valid_ff[rd_addr_ff] <= 1'b1;
         end
         if (accept) begin
            if (req_frame_end) begin
               wait_ff    <= 1'b1;
               pix_cnt_ff <= '0;
            end else if (count_en) begin
               pix_cnt_ff <= pix_cnt_ff + PCNT_W'(1);
            end
         end
         if (bk_req.clear) begin
            valid_ff <= '0;
            wait_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      wr_addr_ff <= rd_addr_ff;
      wr_data_ff <= incr;
      if (accept) begin
         s1_count_ff <= count_en;
         s1_last_ff  <= req_frame_end;
      end
   end

endmodule

[sv/otsu_tok_q.sv]
module otsu_tok_q import otsu_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic pop,
   output logic full,
   output logic empty
);

   logic [TOKQ_CNT_W-1:0] cnt_ff;

   assign full  = cnt_ff == TOKQ_CNT_W'(TOKQ_DEPTH);
   assign empty = cnt_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (push && !pop) begin
         cnt_ff <= cnt_ff + TOKQ_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_ff <= cnt_ff - TOKQ_CNT_W'(1);
      end
   end

endmodule

[sv/otsu_div.sv]
module otsu_div import otsu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [BIN_W-1:0]  den,
   output logic              done,
   output logic [MU_W-1:0]   quo
);

   logic              busy_ff;
   logic              done_ff;
   logic [3:0]        cnt_ff;
   logic [BIN_W-1:0]  rem_ff;
   logic [BIN_W-1:0]  den_ff;
   logic [MU_W-1:0]   lo_ff;
   logic [MU_W-1:0]   quo_ff;
   logic [BIN_W:0]    trial;
   logic [BIN_W:0]    diff;
   logic              qbit;

   // upper part of the numerator is below the divisor, so the quotient fits
   assign trial = {rem_ff, lo_ff[MU_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign qbit  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= BIN_W'(num[NUM_W-1:MU_W]);
         lo_ff  <= num[MU_W-1:0];
         den_ff <= den;
         cnt_ff <= 4'd15;
      end else if (busy_ff) begin
         rem_ff <= qbit ? diff[BIN_W-1:0] : trial[BIN_W-1:0];
         lo_ff  <= {lo_ff[MU_W-2:0], 1'b0};
         quo_ff <= {quo_ff[MU_W-2:0], qbit};
         cnt_ff <= cnt_ff - 4'd1;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

[sv/otsu_back.sv]
module otsu_back import otsu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   input  logic [BIN_W-1:0]  bin_data,
   output back_req_type      bk_req,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_threshold
);

   back_state_type state_ff, state_in;

   logic [7:0]         fixed_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_threshold_ff;
   logic [LVL_W-1:0]   lvl_ff;
   logic [BIN_W-1:0]   tot_w_ff;
   logic [MSUM_W-1:0]  tot_m_ff;
   logic [BIN_W-1:0]   w0_ff, w1_ff;
   logic [MSUM_W-1:0]  m0_ff, m1_ff;
   logic [MU_W-1:0]    d_ff;
   logic [DD_W-1:0]    dd_ff;
   logic [WW_W-1:0]    ww_ff;
   logic [PP_W-1:0]    plo_ff, phi_ff;
   logic [SCORE_W-1:0] best_score_ff;
   logic [LVL_W-1:0]   best_level_ff;

   logic [BIN_W+LVL_W-1:0] ct;
   logic [BIN_W-1:0]   w0_sum, w1_diff;
   logic [MSUM_W-1:0]  m0_sum, m1_diff;
   logic [SCORE_W-1:0] score_sum;
   logic               last_lvl;
   logic               div_start;
   logic               out_load;
   logic               d0_done, d1_done;
   logic [MU_W-1:0]    q0, q1;

   assign ct        = bin_data * lvl_ff;
   assign w0_sum    = w0_ff + bin_data;
   assign m0_sum    = m0_ff + ct[MSUM_W-1:0];
   assign w1_diff   = tot_w_ff - w0_sum;
   assign m1_diff   = tot_m_ff - m0_sum;
   assign last_lvl  = lvl_ff == LVL_W'(LEVELS - 1);
   assign score_sum = SCORE_W'(plo_ff) + {phi_ff, {WH_W{1'b0}}};

   otsu_div u_div0 (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({m0_ff, 8'b0}),
      .den   (w0_ff),
      .done  (d0_done),
      .quo   (q0)
   );

   otsu_div u_div1 (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({m1_ff, 8'b0}),
      .den   (w1_ff),
      .done  (d1_done),
      .quo   (q1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      q_pop          = 1'b0;
      div_start      = 1'b0;
      out_load       = 1'b0;
      bk_req.rd_addr = lvl_ff;
      bk_req.clear   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = BK_SUM_RD;
            end
         end
         BK_SUM_RD:  state_in = BK_SUM_ACC;
         BK_SUM_ACC: state_in = last_lvl ? BK_EV_RD : BK_SUM_RD;
         BK_EV_RD:   state_in = BK_EV_ACC;
         BK_EV_ACC: begin
            // a level with an empty class scores zero and cannot win
            if (w0_sum != '0 && w1_diff != '0) begin
               state_in = BK_DIV_GO;
            end else begin
               state_in = last_lvl ? BK_CLEAR : BK_EV_RD;
            end
         end
         BK_DIV_GO: begin
            div_start = 1'b1;
            state_in  = BK_DIV_WAIT;
         end
         BK_DIV_WAIT: begin
            if (d0_done && d1_done) begin
               state_in = BK_DIFF;
            end
         end
         BK_DIFF:  state_in = BK_SQR;
         BK_SQR:   state_in = BK_PART;
         BK_PART:  state_in = BK_SCORE;
         BK_SCORE: state_in = last_lvl ? BK_CLEAR : BK_EV_RD;
         BK_CLEAR: begin
            bk_req.clear = 1'b1;
            state_in     = BK_EMIT;
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            lvl_ff        <= '0;
            tot_w_ff      <= '0;
            tot_m_ff      <= '0;
            w0_ff         <= '0;
            m0_ff         <= '0;
            best_score_ff <= '0;
            best_level_ff <= '0;
         end
         BK_SUM_ACC: begin
            tot_w_ff <= tot_w_ff + bin_data;
            tot_m_ff <= tot_m_ff + ct[MSUM_W-1:0];
            lvl_ff   <= lvl_ff + LVL_W'(1);
         end
         BK_EV_ACC: begin
            w0_ff <= w0_sum;
            m0_ff <= m0_sum;
            w1_ff <= w1_diff;
            m1_ff <= m1_diff;
            if (w0_sum == '0 || w1_diff == '0) begin
               lvl_ff <= lvl_ff + LVL_W'(1);
            end
         end
         BK_DIFF: d_ff <= (q0 > q1) ? q0 - q1 : q1 - q0;
         BK_SQR: begin
            dd_ff <= d_ff * d_ff;
            ww_ff <= w0_ff * w1_ff;
         end
         BK_PART: begin
            plo_ff <= dd_ff[DD_W-1:8] * ww_ff[WH_W-1:0];
            phi_ff <= dd_ff[DD_W-1:8] * ww_ff[WW_W-1:WH_W];
         end
         BK_SCORE: begin
            if (score_sum > best_score_ff) begin
               best_score_ff <= score_sum;
               best_level_ff <= lvl_ff;
            end
            lvl_ff <= lvl_ff + LVL_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            fixed_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_threshold_ff <= (fixed_ff != '0) ? fixed_ff : best_level_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_threshold = rsp_threshold_ff;

`ifndef SYNTHESIS
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      d0_done == d1_done)
      else $error("class mean dividers out of step");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("token popped from empty queue");

   a_best_monotone: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SCORE) |=> best_score_ff >= $past(best_score_ff))
      else $error("best score decreased");
`endif

endmodule

[sv/otsu_threshold_select_core.sv]
// Pixels: one transfer per cycle while req_ready is high; counting is pipelined two deep.
// Frame end: req_ready falls until the histogram is evaluated; the evaluation reads
// 256 bins for totals, then skips each level with an empty class and runs the
// 16-step mean dividers for every other level.
// The result sits in an output register, and pixels of the next frame are taken meanwhile.
// Reset (synchronous, active high) clears the bin valid flags, counters, queue and override.
module otsu_threshold_select_core import otsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_pixel,
   input  logic       req_frame_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_threshold,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   back_req_type     bk_req;
   logic [BIN_W-1:0] bin_data;
   logic             q_push, q_pop, q_full, q_empty;

   otsu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     (req_pixel),
      .req_frame_end (req_frame_end),
      .bk_req        (bk_req),
      .bin_data      (bin_data),
      .q_full        (q_full),
      .q_push        (q_push)
   );

   otsu_tok_q u_q (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (q_pop),
      .full  (q_full),
      .empty (q_empty)
   );

   otsu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .bin_data      (bin_data),
      .bk_req        (bk_req),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_threshold (rsp_threshold)
   );

endmodule
